// ===== sv/pdll_pkg.sv =====
`timescale 1ns / 1ps
package pdll_pkg;
    localparam int POOL_DEPTH = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W = $clog2(POOL_DEPTH);
    localparam int LINK_W = IDX_W + 1;
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam logic [LINK_W-1:0] NULL_NODE = LINK_W'(POOL_DEPTH);

    typedef enum logic [3:0] {
        ACT_INIT = 4'd0, ACT_PUSH_HEAD = 4'd1, ACT_PUSH_TAIL = 4'd2,
        ACT_POP_HEAD = 4'd3, ACT_POP_TAIL = 4'd4, ACT_INS_BEFORE = 4'd5,
        ACT_INS_AFTER = 4'd6, ACT_FIND = 4'd7, ACT_REMOVE = 4'd8,
        ACT_CLEAR = 4'd9, ACT_WALK = 4'd10
    } action_t;

    localparam logic CFG_POOL_IN_USE = 1'b0;
    localparam logic CFG_MATCH_MASK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INIT, ST_EXEC, ST_POP_FIX, ST_SEARCH, ST_CLEAR, ST_WALK, ST_OUT
    } state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic       load;      // capture input item
        logic       init_step; // rebuild one node link
        logic       exec;      // perform push/insert, else fetch first node (final for pop tail)
        logic       detach;    // unlink current node
        logic       step;      // advance cursor along the list
        logic       clr_step;  // free current node, advance
        logic       clr_done;  // empty list registers
        logic       emit;      // load output register from current state
        logic       emit_node; // output is the current node (pop, find, remove, walk)
        logic       fail;      // result carries ok 0
    } cmd_t;

    typedef struct packed {
        action_t    act;
        logic       pos_bad;
        logic       pool_full;
        logic       list_empty;
        logic       cur_null;
        logic       cur_match;
        logic       init_last;
        logic       init_zero;
        logic       steps_done;
        logic       walk_last; // current node is the final one of the list
    } stat_t;
endpackage

// ===== sv/pdll_datapath.sv =====
`timescale 1ns / 1ps
module pdll_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  pdll_pkg::cmd_t                    cmd,
    output pdll_pkg::stat_t                   stat,
    input  logic [3:0]                        in_action,
    input  logic [pdll_pkg::DATA_WIDTH-1:0]   in_data,
    input  logic [pdll_pkg::IDX_W-1:0]        in_pos,
    input  logic                              in_pos_valid,
    input  logic [pdll_pkg::DATA_WIDTH-1:0]   in_key,
    input  logic                              cfg_we,
    input  logic                              cfg_idx,
    input  logic [31:0]                       cfg_data,
    output logic                              r_ok,
    output logic [pdll_pkg::DATA_WIDTH-1:0]   r_data,
    output logic [pdll_pkg::IDX_W-1:0]        r_node,
    output logic [pdll_pkg::CNT_W-1:0]        r_count,
    output logic                              r_empty
);
    localparam int IW = pdll_pkg::IDX_W;
    localparam int LW = pdll_pkg::LINK_W;
    localparam int CW = pdll_pkg::CNT_W;
    localparam int DW = pdll_pkg::DATA_WIDTH;

    logic [DW-1:0] value_mem [pdll_pkg::POOL_DEPTH];
    logic [LW-1:0] fwd_reg [pdll_pkg::POOL_DEPTH];
    logic [LW-1:0] bwd_reg [pdll_pkg::POOL_DEPTH];
    logic [pdll_pkg::POOL_DEPTH-1:0] linked_reg;
    logic [LW-1:0] first_reg, final_reg, free_reg, cur_reg;
    logic [CW-1:0] count_reg, steps_reg;
    logic [4:0] pool_reg;
    logic [31:0] mask_reg;
    pdll_pkg::action_t act_reg;
    logic [DW-1:0] data_reg, key_reg;
    logic [IW-1:0] pos_reg;
    logic posv_reg;
    logic [CW-1:0] cap;

    assign cap = (pool_reg > 5'(pdll_pkg::POOL_DEPTH)) ? CW'(pdll_pkg::POOL_DEPTH)
                                                      : CW'(pool_reg);

    logic [IW-1:0] cur_i, free_i, pos_i;
    assign cur_i = cur_reg[IW-1:0];
    assign free_i = free_reg[IW-1:0];
    assign pos_i = pos_reg;

    assign stat.act = act_reg;
    assign stat.pos_bad = posv_reg && !linked_reg[pos_i];
    assign stat.pool_full = free_reg >= pdll_pkg::NULL_NODE;
    assign stat.list_empty = first_reg >= pdll_pkg::NULL_NODE;
    assign stat.cur_null = cur_reg >= pdll_pkg::NULL_NODE;
    assign stat.cur_match = !stat.cur_null &&
        (((value_mem[cur_i] ^ key_reg) & DW'(mask_reg)) == '0);
    assign stat.init_last = cur_reg == LW'(pdll_pkg::POOL_DEPTH - 1);
    assign stat.init_zero = pool_reg == 5'd0;
    assign stat.steps_done = steps_reg == CW'(pdll_pkg::POOL_DEPTH);
    assign stat.walk_last = fwd_reg[cur_i] >= pdll_pkg::NULL_NODE ||
                            steps_reg == CW'(pdll_pkg::POOL_DEPTH - 1);

    // effective insert kind after null-position fallback
    logic is_head, is_tail, is_before, is_after;
    always_comb
    begin
        is_head = act_reg == pdll_pkg::ACT_PUSH_HEAD ||
                  (act_reg == pdll_pkg::ACT_INS_BEFORE && !posv_reg);
        is_tail = act_reg == pdll_pkg::ACT_PUSH_TAIL ||
                  (act_reg == pdll_pkg::ACT_INS_AFTER && !posv_reg);
        is_before = act_reg == pdll_pkg::ACT_INS_BEFORE && posv_reg;
        is_after = act_reg == pdll_pkg::ACT_INS_AFTER && posv_reg;
    end

    // element count as it stands once this cycle's update is done
    logic [CW-1:0] count_after;
    always_comb
    begin
        count_after = count_reg;
        if ((cmd.init_step && stat.init_last) || cmd.clr_done)
            count_after = '0;
        else if (cmd.exec && (is_head || is_tail || is_before || is_after) &&
                 !stat.pool_full)
            count_after = count_reg + 1'b1;
        else if (cmd.detach && count_reg != '0)
            count_after = count_reg - 1'b1;
    end

    logic [LW-1:0] j_before, j_after, d_p, d_q;
    always_comb
    begin
        j_before = pdll_pkg::NULL_NODE;
        j_after = pdll_pkg::NULL_NODE;
        if (is_head) j_after = first_reg;
        else if (is_tail) j_before = final_reg;
        else if (is_before) begin j_before = bwd_reg[pos_i]; j_after = LW'(pos_reg); end
        else if (is_after) begin j_before = LW'(pos_reg); j_after = fwd_reg[pos_i]; end
        d_p = bwd_reg[cur_i];
        d_q = fwd_reg[cur_i];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && (is_head || is_tail || is_before || is_after) && !stat.pool_full)
            value_mem[free_i] <= data_reg;
        if (cmd.load)
        begin
            data_reg <= in_data;
            key_reg <= in_key;
            pos_reg <= in_pos;
            posv_reg <= in_pos_valid;
        end
        if (cmd.emit)
        begin
            r_ok <= !cmd.fail;
            r_data <= '0;
            r_node <= '0;
            if (!cmd.fail && cmd.emit_node)
            begin
                r_data <= value_mem[cur_i];
                r_node <= cur_i;
            end
            else if (!cmd.fail && (is_head || is_tail || is_before || is_after))
                r_node <= free_i;
            r_count <= count_after;
            r_empty <= count_after == '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pdll_pkg::POOL_DEPTH; i++)
            begin
                fwd_reg[i] <= (i + 1 < pdll_pkg::POOL_DEPTH) ? LW'(i + 1)
                                                           : pdll_pkg::NULL_NODE;
                bwd_reg[i] <= '0;
            end
            linked_reg <= '0;
            first_reg <= pdll_pkg::NULL_NODE;
            final_reg <= pdll_pkg::NULL_NODE;
            free_reg <= '0;
            count_reg <= '0;
            cur_reg <= '0;
            steps_reg <= '0;
            pool_reg <= 5'd16;
            mask_reg <= '1;
            act_reg <= pdll_pkg::ACT_INIT;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == pdll_pkg::CFG_POOL_IN_USE) pool_reg <= cfg_data[4:0];
                else mask_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                act_reg <= pdll_pkg::action_t'(in_action);
                cur_reg <= '0;
                steps_reg <= '0;
            end
            if (cmd.init_step)
            begin
                fwd_reg[cur_i] <= (CW'(cur_reg) + 1'b1 < cap) ? cur_reg + 1'b1
                                                             : pdll_pkg::NULL_NODE;
                linked_reg[cur_i] <= 1'b0;
                cur_reg <= cur_reg + 1'b1;
                if (stat.init_last)
                begin
                    first_reg <= pdll_pkg::NULL_NODE;
                    final_reg <= pdll_pkg::NULL_NODE;
                    free_reg <= '0;
                    count_reg <= '0;
                end
            end
            if (cmd.exec)
            begin
                if (is_head || is_tail || is_before || is_after)
                begin
                    if (!stat.pool_full)
                    begin
                        free_reg <= fwd_reg[free_i];
                        bwd_reg[free_i] <= j_before;
                        fwd_reg[free_i] <= j_after;
                        if (j_before < pdll_pkg::NULL_NODE) fwd_reg[j_before[IW-1:0]] <= free_reg;
                        else first_reg <= free_reg;
                        if (j_after < pdll_pkg::NULL_NODE) bwd_reg[j_after[IW-1:0]] <= free_reg;
                        else final_reg <= free_reg;
                        linked_reg[free_i] <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                    end
                end
                else if (act_reg == pdll_pkg::ACT_POP_TAIL)
                    cur_reg <= final_reg;
                else
                    cur_reg <= first_reg;
            end
            if (cmd.detach)
            begin
                if (d_p < pdll_pkg::NULL_NODE) fwd_reg[d_p[IW-1:0]] <= d_q;
                else first_reg <= d_q;
                if (d_q < pdll_pkg::NULL_NODE) bwd_reg[d_q[IW-1:0]] <= d_p;
                else final_reg <= d_p;
                if (count_reg != '0) count_reg <= count_reg - 1'b1;
                // give_free after link fixes: detached node's own forward goes to free top
                if (d_p != cur_reg) fwd_reg[cur_i] <= free_reg;
                linked_reg[cur_i] <= 1'b0;
                free_reg <= cur_reg;
            end
            if (cmd.step)
            begin
                cur_reg <= fwd_reg[cur_i];
                steps_reg <= steps_reg + 1'b1;
            end
            if (cmd.clr_step)
            begin
                fwd_reg[cur_i] <= free_reg;
                linked_reg[cur_i] <= 1'b0;
                free_reg <= cur_reg;
                cur_reg <= fwd_reg[cur_i];
                steps_reg <= steps_reg + 1'b1;
            end
            if (cmd.clr_done)
            begin
                first_reg <= pdll_pkg::NULL_NODE;
                final_reg <= pdll_pkg::NULL_NODE;
                count_reg <= '0;
            end
        end
    end
endmodule

// ===== sv/pdll_ctrl.sv =====
`timescale 1ns / 1ps
module pdll_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  pdll_pkg::stat_t  stat,
    input  logic             in_fire,
    input  logic             out_fire,
    output logic             in_ready,
    output logic             out_valid,
    output logic             out_last,
    output pdll_pkg::cmd_t   cmd
);
    pdll_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next, last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdll_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            last_reg <= last_next;
        end
    end

    assign in_ready = state_reg == pdll_pkg::ST_IDLE && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_last = last_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        out_valid_next = out_valid_reg && !out_fire;
        last_next = last_reg;
        unique case (state_reg)
            pdll_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = pdll_pkg::ST_EXEC;
                end
            end
            pdll_pkg::ST_EXEC:
            begin
                unique case (stat.act)
                    pdll_pkg::ACT_INIT:
                        if (stat.init_zero)
                        begin
                            cmd.fail = 1'b1;
                            state_next = pdll_pkg::ST_OUT;
                        end
                        else
                            state_next = pdll_pkg::ST_INIT;
                    pdll_pkg::ACT_PUSH_HEAD, pdll_pkg::ACT_PUSH_TAIL,
                    pdll_pkg::ACT_INS_BEFORE, pdll_pkg::ACT_INS_AFTER:
                    begin
                        if ((stat.act == pdll_pkg::ACT_INS_BEFORE ||
                             stat.act == pdll_pkg::ACT_INS_AFTER) && stat.pos_bad)
                            cmd.fail = 1'b1;
                        else if (stat.pool_full)
                            cmd.fail = 1'b1;
                        else
                            cmd.exec = 1'b1;
                        // emit node index before the free pointer moves
                        cmd.emit = 1'b1;
                        out_valid_next = 1'b1;
                        last_next = 1'b1;
                        state_next = pdll_pkg::ST_OUT;
                    end
                    pdll_pkg::ACT_POP_HEAD, pdll_pkg::ACT_POP_TAIL:
                    begin
                        cmd.exec = 1'b1;
                        state_next = pdll_pkg::ST_POP_FIX;
                    end
                    pdll_pkg::ACT_FIND, pdll_pkg::ACT_REMOVE:
                    begin
                        cmd.exec = 1'b1;
                        state_next = pdll_pkg::ST_SEARCH;
                    end
                    pdll_pkg::ACT_CLEAR:
                    begin
                        cmd.exec = 1'b1;
                        state_next = pdll_pkg::ST_CLEAR;
                    end
                    pdll_pkg::ACT_WALK:
                    begin
                        cmd.exec = 1'b1;
                        state_next = pdll_pkg::ST_WALK;
                    end
                    default:
                    begin
                        cmd.fail = 1'b1;
                        state_next = pdll_pkg::ST_OUT;
                    end
                endcase
                if (state_next == pdll_pkg::ST_OUT && !cmd.emit)
                begin
                    cmd.emit = 1'b1;
                    out_valid_next = 1'b1;
                    last_next = 1'b1;
                end
            end
            pdll_pkg::ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (stat.init_last)
                    state_next = pdll_pkg::ST_OUT;
            end
            pdll_pkg::ST_POP_FIX:
            begin
                cmd.emit = 1'b1;
                cmd.emit_node = 1'b1;
                cmd.fail = stat.cur_null;
                cmd.detach = !stat.cur_null;
                out_valid_next = 1'b1;
                last_next = 1'b1;
                state_next = pdll_pkg::ST_OUT;
            end
            pdll_pkg::ST_SEARCH:
            begin
                if (stat.cur_match)
                begin
                    cmd.detach = stat.act == pdll_pkg::ACT_REMOVE;
                    cmd.emit = 1'b1;
                    cmd.emit_node = 1'b1;
                    out_valid_next = 1'b1;
                    last_next = 1'b1;
                    state_next = pdll_pkg::ST_OUT;
                end
                else if (stat.cur_null || stat.steps_done)
                begin
                    cmd.emit = 1'b1;
                    cmd.fail = 1'b1;
                    out_valid_next = 1'b1;
                    last_next = 1'b1;
                    state_next = pdll_pkg::ST_OUT;
                end
                else
                    cmd.step = 1'b1;
            end
            pdll_pkg::ST_CLEAR:
            begin
                if (stat.cur_null || stat.steps_done)
                begin
                    cmd.clr_done = 1'b1;
                    state_next = pdll_pkg::ST_OUT;
                end
                else
                    cmd.clr_step = 1'b1;
            end
            pdll_pkg::ST_WALK:
            begin
                if (!out_valid_reg || out_fire)
                begin
                    if (stat.cur_null || stat.steps_done)
                    begin
                        if (stat.list_empty)
                        begin
                            cmd.emit = 1'b1;
                            cmd.fail = 1'b1;
                            out_valid_next = 1'b1;
                            last_next = 1'b1;
                        end
                        state_next = pdll_pkg::ST_OUT;
                    end
                    else
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_node = 1'b1;
                        cmd.step = 1'b1;
                        out_valid_next = 1'b1;
                        // final node of the list closes the transaction run
                        last_next = stat.walk_last;
                        if (stat.walk_last)
                            state_next = pdll_pkg::ST_OUT;
                    end
                end
            end
            pdll_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_fire)
                    state_next = pdll_pkg::ST_IDLE;
            end
            default: state_next = pdll_pkg::ST_IDLE;
        endcase
        // init and clear results are produced when their sweep ends
        if ((state_reg == pdll_pkg::ST_INIT && stat.init_last) ||
            (state_reg == pdll_pkg::ST_CLEAR && state_next == pdll_pkg::ST_OUT))
        begin
            cmd.emit = 1'b1;
            out_valid_next = 1'b1;
            last_next = 1'b1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> !in_ready);
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_fire))
        else $error("result overwritten");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pdll_pkg::ST_IDLE) |-> !(out_valid_reg && !last_reg))
        else $error("idle with open walk");
endmodule

// ===== sv/pooled_doubly_linked_list.sv =====
`timescale 1ns / 1ps
// Doubly linked list of 32-bit words in a 16-node pool with a free stack.
// One item is taken at a time; the next item is accepted once the final
// result is taken. Init sweeps all 16 link entries; find, remove and clear
// step through the list node by node; walk gives one result a cycle,
// held off by m_tready back-pressure on the output register.
// Configuration writes are accepted at any time but belong in idle periods.
module pooled_doubly_linked_list
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: action[3:0], data_in[35:4], position_node[39:36],
    //        position_valid[40], search_key[72:41], zeros[79:73]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: ok[0], data_out[32:1], node_out[36:33], element_count[41:37],
    //        is_empty[42], zeros[47:43]
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    pdll_pkg::cmd_t cmd;
    pdll_pkg::stat_t stat;
    logic r_ok, r_empty;
    logic [31:0] r_data;
    logic [3:0] r_node;
    logic [4:0] r_count;

    assign cfg_ready = 1'b1;

    pdll_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .stat(stat),
        .in_fire(s_tvalid && s_tready), .out_fire(m_tvalid && m_tready),
        .in_ready(s_tready), .out_valid(m_tvalid), .out_last(m_tlast), .cmd(cmd)
    );

    pdll_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_action(s_tdata[3:0]), .in_data(s_tdata[35:4]), .in_pos(s_tdata[39:36]),
        .in_pos_valid(s_tdata[40]), .in_key(s_tdata[72:41]),
        .cfg_we(cfg_valid), .cfg_idx(cfg_index[0]), .cfg_data(cfg_data),
        .r_ok(r_ok), .r_data(r_data), .r_node(r_node), .r_count(r_count),
        .r_empty(r_empty)
    );

    assign m_tdata = {5'd0, r_empty, r_count, r_node, r_data, r_ok};
endmodule

// ===== tb/sv/pooled_doubly_linked_list_checker.sv =====
`timescale 1ns / 1ps
module pooled_doubly_linked_list_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          pending,
    output int          results_seen
);
    localparam int PD = pdll_pkg::POOL_DEPTH;
    localparam logic [4:0] NN = 5'(pdll_pkg::POOL_DEPTH);

    typedef struct packed {
        logic        ok;
        logic [31:0] data;
        logic [3:0]  node;
        logic [4:0]  count;
        logic        empty;
        logic        last;
    } list_result_t;

    list_result_t expected_results[$];

    logic [31:0] value_mem [PD];
    logic [4:0]  fwd_link [PD];
    logic [4:0]  back_link [PD];
    logic        in_list [PD];
    logic [4:0]  head, tail, free_head, length;
    logic [4:0]  pool_size;
    logic [31:0] key_mask;

    function automatic void queue_result(logic ok, logic [31:0] d, logic [3:0] n);
        list_result_t r;
        r.ok = ok;
        r.data = d;
        r.node = n;
        r.count = length;
        r.empty = (length == '0);
        r.last = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic logic rebuild_pool(logic [4:0] cap);
        if (cap == '0)
            return 1'b0;
        if (cap > NN)
            cap = NN;
        for (int i = 0; i < PD; i++)
        begin
            in_list[i] = 1'b0;
            fwd_link[i] = (i + 1 < int'(cap)) ? 5'(i + 1) : NN;
        end
        head = NN;
        tail = NN;
        free_head = '0;
        length = '0;
        return 1'b1;
    endfunction

    function automatic void push_free(logic [4:0] n);
        fwd_link[n[3:0]] = free_head;
        in_list[n[3:0]] = 1'b0;
        free_head = n;
    endfunction

    function automatic void link_node(logic [4:0] n, logic [4:0] p, logic [4:0] q,
                                      logic [31:0] d);
        value_mem[n[3:0]] = d;
        back_link[n[3:0]] = p;
        fwd_link[n[3:0]] = q;
        if (p < NN) fwd_link[p[3:0]] = n; else head = n;
        if (q < NN) back_link[q[3:0]] = n; else tail = n;
        in_list[n[3:0]] = 1'b1;
        length++;
    endfunction

    function automatic void unlink_node(logic [4:0] n);
        logic [4:0] p, q;
        p = back_link[n[3:0]];
        q = fwd_link[n[3:0]];
        if (p < NN) fwd_link[p[3:0]] = q; else head = q;
        if (q < NN) back_link[q[3:0]] = p; else tail = p;
        if (length > 0) length--;
        push_free(n);
    endfunction

    function automatic void apply_action(logic [79:0] item);
        pdll_pkg::action_t act;
        logic [31:0] d, key;
        logic [3:0] pos;
        logic pos_ok;
        logic [4:0] n, cur, nxt;
        int k;
        act = pdll_pkg::action_t'(item[3:0]);
        d = item[35:4];
        pos = item[39:36];
        pos_ok = item[40];
        key = item[72:41];
        k = 0;
        if (act == pdll_pkg::ACT_INS_BEFORE || act == pdll_pkg::ACT_INS_AFTER)
        begin
            if (!pos_ok)
                act = (act == pdll_pkg::ACT_INS_BEFORE) ? pdll_pkg::ACT_PUSH_HEAD
                                                        : pdll_pkg::ACT_PUSH_TAIL;
            else if (!in_list[pos])
            begin
                queue_result(0, 0, 0);
                expected_results[$].last = 1'b1;
                return;
            end
        end
        case (act)
            pdll_pkg::ACT_INIT: queue_result(rebuild_pool(pool_size), 0, 0);
            pdll_pkg::ACT_PUSH_HEAD, pdll_pkg::ACT_PUSH_TAIL,
            pdll_pkg::ACT_INS_BEFORE, pdll_pkg::ACT_INS_AFTER:
            begin
                n = free_head;
                if (n >= NN)
                    queue_result(0, 0, 0);
                else
                begin
                    free_head = fwd_link[n[3:0]];
                    if (act == pdll_pkg::ACT_PUSH_HEAD) link_node(n, NN, head, d);
                    else if (act == pdll_pkg::ACT_PUSH_TAIL) link_node(n, tail, NN, d);
                    else if (act == pdll_pkg::ACT_INS_BEFORE)
                        link_node(n, back_link[pos], {1'b0, pos}, d);
                    else link_node(n, {1'b0, pos}, fwd_link[pos], d);
                    queue_result(1, 0, n[3:0]);
                end
            end
            pdll_pkg::ACT_POP_HEAD, pdll_pkg::ACT_POP_TAIL:
            begin
                n = (act == pdll_pkg::ACT_POP_HEAD) ? head : tail;
                if (n >= NN)
                    queue_result(0, 0, 0);
                else
                begin
                    d = value_mem[n[3:0]];
                    unlink_node(n);
                    queue_result(1, d, n[3:0]);
                end
            end
            pdll_pkg::ACT_FIND, pdll_pkg::ACT_REMOVE:
            begin
                n = NN;
                cur = head;
                for (int s = 0; s < PD && cur < NN; s++)
                begin
                    if (((value_mem[cur[3:0]] ^ key) & key_mask) == '0)
                    begin
                        n = cur;
                        break;
                    end
                    cur = fwd_link[cur[3:0]];
                end
                if (n >= NN)
                    queue_result(0, 0, 0);
                else
                begin
                    d = value_mem[n[3:0]];
                    if (act == pdll_pkg::ACT_REMOVE) unlink_node(n);
                    queue_result(1, d, n[3:0]);
                end
            end
            pdll_pkg::ACT_CLEAR:
            begin
                cur = head;
                for (int s = 0; s < PD && cur < NN; s++)
                begin
                    nxt = fwd_link[cur[3:0]];
                    push_free(cur);
                    cur = nxt;
                end
                head = NN;
                tail = NN;
                length = '0;
                queue_result(1, 0, 0);
            end
            pdll_pkg::ACT_WALK:
            begin
                cur = head;
                for (int s = 0; s < PD && cur < NN; s++)
                begin
                    queue_result(1, value_mem[cur[3:0]], cur[3:0]);
                    k++;
                    cur = fwd_link[cur[3:0]];
                end
                if (k == 0) queue_result(0, 0, 0);
            end
            default: queue_result(0, 0, 0);
        endcase
        expected_results[$].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t got, want;
        if (!rst_n)
        begin
            expected_results.delete();
            mismatches <= 0;
            results_seen <= 0;
            pending <= 0;
            pool_size = 5'd16;
            key_mask = '1;
            for (int i = 0; i < PD; i++)
            begin
                value_mem[i] = '0;
                back_link[i] = '0;
            end
            void'(rebuild_pool(pool_size));
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == pdll_pkg::CFG_POOL_IN_USE) pool_size = cfg_data[4:0];
                else key_mask = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                got = {m_tdata[0], m_tdata[32:1], m_tdata[36:33], m_tdata[41:37],
                       m_tdata[42], m_tlast};
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("ERROR: unexpected result %h", got);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display("ERROR: ok %b/%b data %h/%h node %0d/%0d cnt %0d/%0d empty %b/%b last %b/%b (exp/act)",
                                     want.ok, got.ok, want.data, got.data, want.node, got.node,
                                     want.count, got.count, want.empty, got.empty,
                                     want.last, got.last);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            // outputs seen this cycle belong to older items and were checked above
            if (s_tvalid && s_tready)
                apply_action(s_tdata);
            pending <= expected_results.size();
        end
    end
endmodule

// ===== tb/sv/pooled_doubly_linked_list_test.sv =====
`timescale 1ns / 1ps
module pooled_doubly_linked_list_test;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          mismatches, pending, results_seen;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          long_hold = 0;
    bit          timed_out = 0;

    always #1 clk = ~clk;

    pooled_doubly_linked_list dut (.*);

    pooled_doubly_linked_list_checker checker_i (.*);

    // receiver: random stalls, plus one long hold-off on request
    always
    begin
        int gap;
        @(posedge clk);
        if (long_hold)
        begin
            m_tready <= 1'b0;
            repeat (150) @(posedge clk);
            long_hold = 0;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        m_tready <= 1'b1;
        do @(posedge clk); while (!(m_tvalid && m_tready));
        m_tready <= ($urandom_range(0, 1) == 1);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !timed_out)
        begin
            timed_out = 1;
            $display("Test completed with failures");
            $finish;
        end
    end

    // valid stays up across back-to-back items; drop it only for a gap
    task automatic send_item(pdll_pkg::action_t act, logic [31:0] d, logic [3:0] pos,
                             logic pv, logic [31:0] key, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, key, pv, pos, d, act};
        do @(posedge clk); while (!(s_tvalid && s_tready));
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int count, int max_pos);
        pdll_pkg::action_t act;
        logic [31:0] d;
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 20) act = pdll_pkg::ACT_PUSH_TAIL;
            else if (r < 32) act = pdll_pkg::ACT_PUSH_HEAD;
            else if (r < 40) act = pdll_pkg::ACT_POP_HEAD;
            else if (r < 47) act = pdll_pkg::ACT_POP_TAIL;
            else if (r < 57) act = pdll_pkg::ACT_INS_BEFORE;
            else if (r < 67) act = pdll_pkg::ACT_INS_AFTER;
            else if (r < 76) act = pdll_pkg::ACT_FIND;
            else if (r < 84) act = pdll_pkg::ACT_REMOVE;
            else if (r < 87) act = pdll_pkg::ACT_CLEAR;
            else if (r < 95) act = pdll_pkg::ACT_WALK;
            else if (r < 97) act = pdll_pkg::ACT_INIT;
            else act = pdll_pkg::action_t'($urandom_range(11, 15));
            d = pick_word();
            send_item(act, d, 4'($urandom_range(0, max_pos)), ($urandom_range(0, 4) != 0),
                      ($urandom_range(0, 1) ? d : pick_word()), $urandom_range(0, 4) == 0);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, full pool, fallbacks, bad position, unknown action
        send_item(pdll_pkg::ACT_POP_HEAD, 0, 0, 0, 0, 0);
        send_item(pdll_pkg::ACT_POP_TAIL, 0, 0, 0, 0, 0);
        send_item(pdll_pkg::ACT_WALK, 0, 0, 0, 0, 0);
        send_item(pdll_pkg::ACT_FIND, 0, 0, 0, 0, 0);
        send_item(pdll_pkg::ACT_INS_AFTER, 32'h1, 4'd3, 1, 0, 0);
        send_item(pdll_pkg::ACT_INS_BEFORE, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_item(pdll_pkg::ACT_INS_AFTER, 32'h0, 0, 0, 0, 0);
        send_item(pdll_pkg::ACT_PUSH_HEAD, 32'hA5A5_5A5A, 0, 0, 0, 0);
        send_item(pdll_pkg::ACT_PUSH_TAIL, 32'h5A5A_A5A5, 0, 0, 0, 0);
        send_item(pdll_pkg::ACT_INS_BEFORE, 32'h1234_5678, 4'd1, 1, 0, 0);
        send_item(pdll_pkg::ACT_INS_AFTER, 32'h8765_4321, 4'd15, 1, 0, 0);
        send_item(pdll_pkg::ACT_INS_AFTER, 32'hDEAD_BEEF, 4'd0, 1, 0, 0);
        send_item(pdll_pkg::ACT_FIND, 0, 0, 0, 32'h5A5A_A5A5, 0);
        send_item(pdll_pkg::ACT_REMOVE, 0, 0, 0, 32'h1234_5678, 0);
        send_item(pdll_pkg::ACT_REMOVE, 0, 0, 0, 32'h0BAD_0BAD, 0);
        send_item(pdll_pkg::ACT_WALK, 0, 0, 0, 0, 0);
        send_item(pdll_pkg::action_t'(4'd15), '1, 4'd15, 1, '1, 0);
        send_item(pdll_pkg::action_t'(4'd11), 0, 0, 0, 0, 0);
        send_item(pdll_pkg::ACT_CLEAR, 0, 0, 0, 0, 0);
        send_item(pdll_pkg::ACT_CLEAR, 0, 0, 0, 0, 0);
        for (int i = 0; i < 17; i++)
            send_item(pdll_pkg::ACT_PUSH_TAIL, $urandom, 0, 0, 0, 1);
        send_item(pdll_pkg::ACT_WALK, 0, 0, 0, 0, 0);
        send_item(pdll_pkg::ACT_INIT, 0, 0, 0, 0, 0);
        drain();

        // pool_in_use zero: init fails; then above the pool: saturates
        write_reg(pdll_pkg::CFG_POOL_IN_USE, 0);
        send_item(pdll_pkg::ACT_INIT, 0, 0, 0, 0, 0);
        drain();
        write_reg(pdll_pkg::CFG_POOL_IN_USE, 31);
        write_reg(pdll_pkg::CFG_MATCH_MASK, 32'h0000_00FF);
        send_item(pdll_pkg::ACT_INIT, 0, 0, 0, 0, 0);
        random_phase(60, 15);
        drain();

        write_reg(pdll_pkg::CFG_POOL_IN_USE, 1);
        write_reg(pdll_pkg::CFG_MATCH_MASK, 32'h0);
        send_item(pdll_pkg::ACT_INIT, 0, 0, 0, 0, 0);
        random_phase(30, 3);
        drain();

        write_reg(pdll_pkg::CFG_POOL_IN_USE, 5);
        write_reg(pdll_pkg::CFG_MATCH_MASK, 32'h8000_0007);
        send_item(pdll_pkg::ACT_INIT, 0, 0, 0, 0, 0);
        random_phase(60, 7);
        drain();

        // fill up, then hold the receiver off while a run of walks waits on it
        write_reg(pdll_pkg::CFG_POOL_IN_USE, 16);
        write_reg(pdll_pkg::CFG_MATCH_MASK, 32'hFFFF_FFFF);
        send_item(pdll_pkg::ACT_INIT, 0, 0, 0, 0, 0);
        for (int i = 0; i < 16; i++)
            send_item(pdll_pkg::ACT_PUSH_HEAD, $urandom, 0, 0, 0, 1);
        long_hold = 1;
        for (int i = 0; i < 4; i++)
            send_item(pdll_pkg::ACT_WALK, 0, 0, 0, 0, 1);
        random_phase(56, 15);
        drain();

        $display("Sent %0d list actions, checked %0d results over pool sizes 0..31",
                 items_sent, results_seen);
        $display("and masks from zero to all ones, with long output stalls.");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
